>>> hdl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg: shared types and constants for the request flood detector
// Beat layouts, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rfd_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int WINDOW_DEF      = 10;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TIME     = 2'd2;

  localparam logic [31:0] BASE_THRESHOLD_RST = 32'd100;
  localparam logic [16:0] SMOOTHING_RST      = 17'd6554;
  localparam logic [31:0] BLOCK_TIME_RST     = 32'd300000;
  localparam logic [16:0] Q16_ONE            = 17'd65536;

  typedef struct packed {
    logic        req_type;
    logic [31:0] client_ip;
    logic [31:0] now_ms;
  } rfd_in_t;

  typedef struct packed {
    logic        request_rejected;
    logic        alert_active;
    logic        newly_blocked;
    logic [31:0] threshold_whole;
    logic [31:0] interval_count;
    logic [4:0]  entries_in_use;
  } rfd_out_t;

endpackage
`default_nettype wire

>>> hdl/rfd_ram.sv
// ----------------------------------------------------------------------------
// rfd_ram: generic single-port RAM
// One read per cycle, with an optional write to the same address; read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire  logic                                      clk,
  input  wire  logic                                      we,
  input  wire  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire  logic [WIDTH-1:0]                          wdata,
  output logic       [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> hdl/request_flood_detector_blocklist.sv
// ----------------------------------------------------------------------------
// request_flood_detector_blocklist: adaptive-threshold flood detector
// Counts requests per interval, tracks an EMA threshold and keeps a timed
// table of blocked client addresses.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the beat is taken on the
//   edge where start is high and busy is low. busy stays high until the
//   result beat is shown.
//   Result channel: done is high for exactly one cycle with the result on
//   result. The receiver cannot stall; the beat is gone after that cycle.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data.
//   cfg_ready is high only while idle. Index 0 reloads the threshold,
//   index 3 is ignored.
// Processing:
//   Request: table walk through the entry RAM, one entry per cycle, then
//   read latency, drain and result.
//   Tick: the same walk, then the reciprocal multiply of the ring sum by
//   1/WINDOW (four partial products) and the two EMA steps.
//   One item at a time: no new beat is taken until the result is shown.
// Reset: rst (sync) empties the table (valid bits), zeros the ring and
//   tally, and reloads the threshold from its reset base. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module request_flood_detector_blocklist #(
  parameter int TABLE_DEPTH = rfd_pkg::TABLE_DEPTH_DEF,
  parameter int WINDOW      = rfd_pkg::WINDOW_DEF
) (
  input  wire  logic                           clk,
  input  wire  logic                           rst,
  input  wire  logic                           start,
  output logic                                 busy,
  input  wire  rfd_pkg::rfd_in_t               cmd,
  output logic                                 done,
  output rfd_pkg::rfd_out_t                    result,
  input  wire  logic                           cfg_valid,
  output logic                                 cfg_ready,
  input  wire  logic [rfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  logic [31:0]                    cfg_data
);
  import rfd_pkg::*;

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int RW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = 32 + $clog2(WINDOW) + 1;
  // floor(x / WINDOW) = (x * RECIP) >> KSH, exact for any x below 2^SUM_W
  localparam int KSH   = SUM_W + $clog2(WINDOW);
  localparam logic [63:0] RECIP =
    ((64'd1 << KSH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam int HX    = (SUM_W + 1) / 2;
  localparam int HM    = (SUM_W + 2) / 2;
  localparam int PW    = 2 * HX + 2 * HM;
  localparam logic [2*HM-1:0] RECIP_W = (2 * HM)'(RECIP);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ADD  = 3'd4;

  logic [2:0] state;

  // configuration
  logic [16:0] smoothing;
  logic [31:0] block_time;

  // detector state
  logic [31:0]      tally;
  logic [31:0]      last_client;
  logic             last_client_valid;
  logic [47:0]      threshold;
  logic             alert;
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [WINDOW-1:0]      ring_valid;
  logic [RW-1:0]    ring_ptr;
  logic [SUM_W-1:0] ring_sum;

  // per-item working registers
  rfd_in_t   item;
  logic [CW-1:0] cnt;
  logic          proc_v;
  logic [AW-1:0] proc_idx;
  logic          listed;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic [CW-1:0] live;
  logic [31:0]   shown;
  logic [SUM_W-1:0] quo;
  logic [PW-1:0]    div_acc;
  logic [1:0]       div_cnt;
  logic [64:0]      prod_t;
  logic [48:0]      prod_a;

  // table RAM: {address, expiry}
  logic          tbl_we;
  logic [AW-1:0] tbl_addr;
  logic [63:0]   tbl_wdata;
  logic [63:0]   tbl_rdata;

  logic          ring_we;
  logic [31:0]   ring_rdata;
  logic [31:0]   ring_old;

  rfd_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .addr  (tbl_addr),
    .wdata (tbl_wdata),
    .rdata (tbl_rdata)
  );

  rfd_ram #(.WIDTH(32), .DEPTH(WINDOW)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .addr  (ring_ptr),
    .wdata (tally),
    .rdata (ring_rdata)
  );

  // never-written ring slots read as zero
  assign ring_old = ring_valid[ring_ptr] ? ring_rdata : 32'd0;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = ~busy;

  // walk decode
  logic [31:0] key;
  logic        ent_expired;
  logic        ent_live;
  logic        walk_end;
  assign key         = item.req_type ? last_client : item.client_ip;
  assign ent_expired = ~(item.now_ms - tbl_rdata[31:0]) >> 31 == 32'd1;
  assign ent_live    = entry_valid[proc_idx] & ~ent_expired;
  assign walk_end    = (cnt == CW'(TABLE_DEPTH)) & ~proc_v;

  // reciprocal multiply, one partial product per cycle
  logic [2*HX-1:0]  dvd_ext;
  logic [HX-1:0]    mul_x;
  logic [HM-1:0]    mul_m;
  logic [HX+HM-1:0] pp;
  logic [PW-1:0]    pp_sh;
  logic [31:0]      avg;
  assign dvd_ext = (2 * HX)'(quo);
  assign mul_x   = div_cnt[1] ? dvd_ext[2*HX-1:HX] : dvd_ext[HX-1:0];
  assign mul_m   = div_cnt[0] ? RECIP_W[2*HM-1:HM] : RECIP_W[HM-1:0];
  assign pp      = mul_x * mul_m;
  assign avg     = div_acc[KSH +: 32];

  always_comb begin
    case (div_cnt)
      2'd0:    pp_sh = PW'(pp);
      2'd1:    pp_sh = PW'(pp) << HM;
      2'd2:    pp_sh = PW'(pp) << HX;
      2'd3:    pp_sh = PW'(pp) << (HX + HM);
      default: pp_sh = PW'(pp);
    endcase
  end

  // EMA
  logic [16:0] s_eff;
  logic [65:0] ema_sum;
  logic [47:0] thr_next;
  logic        alert_next;
  logic        do_insert;
  assign s_eff      = (smoothing > Q16_ONE) ? Q16_ONE : smoothing;
  assign ema_sum    = {1'b0, prod_t} + {1'b0, prod_a, 16'd0} + 66'd32768;
  assign thr_next   = ema_sum[63:16];
  assign alert_next = {shown, 16'd0} > thr_next;
  assign do_insert  = alert_next & last_client_valid & ~listed & free_found;

  always_comb begin
    tbl_we    = 1'b0;
    tbl_addr  = cnt[AW-1:0];
    tbl_wdata = {last_client, item.now_ms + block_time};
    if (state == ST_ADD) begin
      tbl_addr = free_idx;
      tbl_we   = do_insert;
    end
  end

  assign ring_we = (state == ST_WALK) & walk_end & item.req_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      smoothing         <= SMOOTHING_RST;
      block_time        <= BLOCK_TIME_RST;
      tally             <= 32'd0;
      last_client       <= 32'd0;
      last_client_valid <= 1'b0;
      threshold         <= {BASE_THRESHOLD_RST, 16'd0};
      alert             <= 1'b0;
      entry_valid       <= '0;
      ring_valid        <= '0;
      ring_ptr          <= '0;
      ring_sum          <= '0;
      done              <= 1'b0;
    end else begin
      // result strobe: request ends with the walk, tick with the EMA step
      done <= ((state == ST_WALK) && walk_end && !item.req_type) || (state == ST_ADD);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE_THRESHOLD: threshold  <= {cfg_data, 16'd0};
          CFG_SMOOTHING:      smoothing  <= cfg_data[16:0];
          CFG_BLOCK_TIME:     block_time <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            item       <= cmd;
            cnt        <= '0;
            proc_v     <= 1'b0;
            listed     <= 1'b0;
            free_found <= 1'b0;
            free_idx   <= '0;
            live       <= '0;
            state      <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (cnt != CW'(TABLE_DEPTH)) begin
            cnt <= cnt + CW'(1);
          end
          proc_v   <= (cnt != CW'(TABLE_DEPTH));
          proc_idx <= cnt[AW-1:0];
          if (proc_v) begin
            if (entry_valid[proc_idx] & ent_expired) begin
              entry_valid[proc_idx] <= 1'b0;
            end
            if (ent_live) begin
              live <= live + CW'(1);
              if (tbl_rdata[63:32] == key) begin
                listed <= 1'b1;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_idx   <= proc_idx;
            end
          end
          if (walk_end) begin
            if (!item.req_type) begin
              if (!listed) begin
                if (tally != 32'hFFFF_FFFF) begin
                  tally <= tally + 32'd1;
                end
                last_client       <= item.client_ip;
                last_client_valid <= 1'b1;
              end
              result.request_rejected <= listed;
              result.alert_active     <= alert;
              result.newly_blocked    <= 1'b0;
              result.threshold_whole  <= threshold[47:16];
              result.interval_count   <= (!listed && tally != 32'hFFFF_FFFF) ?
                                         tally + 32'd1 : tally;
              result.entries_in_use   <= 5'(live);
              state <= ST_IDLE;
            end else begin
              // fold the closing tally into the ring and its running sum
              ring_sum   <= ring_sum - SUM_W'(ring_old) + SUM_W'(tally);
              quo        <= ring_sum - SUM_W'(ring_old) + SUM_W'(tally);
              ring_valid[ring_ptr] <= 1'b1;
              ring_ptr   <= (ring_ptr == RW'(WINDOW - 1)) ? '0 : ring_ptr + RW'(1);
              shown      <= tally;
              tally      <= 32'd0;
              div_acc    <= '0;
              div_cnt    <= '0;
              state      <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // ring sum times the reciprocal of WINDOW, four partial products
          div_acc <= div_acc + pp_sh;
          div_cnt <= div_cnt + 2'd1;
          if (div_cnt == 2'd3) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_t <= threshold * (Q16_ONE - s_eff);
          prod_a <= avg * s_eff;
          state  <= ST_ADD;
        end
        ST_ADD: begin
          threshold <= thr_next;
          alert     <= alert_next;
          if (do_insert) begin
            entry_valid[free_idx] <= 1'b1;
          end
          result.request_rejected <= 1'b0;
          result.alert_active     <= alert_next;
          result.newly_blocked    <= do_insert;
          result.threshold_whole  <= thr_next[47:16];
          result.interval_count   <= shown;
          result.entries_in_use   <= 5'(live + CW'(do_insert));
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for request_flood_detector_blocklist
// Drives request, tick and config beats, predicts each result beat from an
// internal model of the tally, the ring, the EMA threshold and the block
// table, and compares every result beat field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import rfd_pkg::*;

  localparam int DEPTH      = TABLE_DEPTH_DEF;
  localparam int RING_LEN   = WINDOW_DEF;
  localparam int CYCLE_CAP  = 2000000;
  localparam int DRAIN_WAIT = 80;
  localparam logic REQ_CLIENT = 1'b0;
  localparam logic REQ_TICK   = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  rfd_in_t          cmd = '0;
  logic             done;
  rfd_out_t         result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]      cfg_data = '0;

  always #1 clk = ~clk;

  request_flood_detector_blocklist u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // --- detector model state ---
  logic [16:0] m_smooth;
  logic [31:0] m_block_ms;
  logic [31:0] m_tally;
  logic [31:0] m_last_ip;
  logic        m_last_ok;
  logic [31:0] m_ring [RING_LEN];
  int          m_ptr;
  logic [63:0] m_thresh;
  logic        m_alert;
  logic [31:0] m_addr [DEPTH];
  logic [31:0] m_expiry [DEPTH];
  logic        m_live [DEPTH];

  rfd_out_t    pending_results [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          gap_pct = 0;
  logic [31:0] now_clock;
  logic [31:0] ip_pool [24];

  function automatic logic listed(logic [31:0] ip);
    for (int i = 0; i < DEPTH; i++)
      if (m_live[i] && m_addr[i] == ip) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void model_reset();
    m_smooth = SMOOTHING_RST;
    m_block_ms = BLOCK_TIME_RST;
    m_tally = '0;
    m_last_ip = '0;
    m_last_ok = 1'b0;
    for (int i = 0; i < RING_LEN; i++) m_ring[i] = '0;
    m_ptr = 0;
    m_thresh = {32'd0, BASE_THRESHOLD_RST} << 16;
    m_alert = 1'b0;
    for (int i = 0; i < DEPTH; i++) m_live[i] = 1'b0;
  endfunction

  function automatic rfd_out_t detector_step(rfd_in_t item);
    rfd_out_t    r;
    logic [31:0] age;
    logic [39:0] sum;
    logic [79:0] avg, s, t, mix;
    int          cnt;
    r = '0;
    // expiry is wrap-safe: expired once now has reached the stamp
    for (int i = 0; i < DEPTH; i++) begin
      age = item.now_ms - m_expiry[i];
      if (m_live[i] && !age[31]) m_live[i] = 1'b0;
    end
    if (item.req_type == REQ_CLIENT) begin
      if (listed(item.client_ip)) begin
        r.request_rejected = 1'b1;
      end else begin
        if (m_tally != 32'hFFFF_FFFF) m_tally++;
        m_last_ip = item.client_ip;
        m_last_ok = 1'b1;
      end
      r.interval_count = m_tally;
    end else begin
      m_ring[m_ptr] = m_tally;
      m_ptr = (m_ptr + 1) % RING_LEN;
      sum = '0;
      for (int i = 0; i < RING_LEN; i++) sum += m_ring[i];
      avg = sum / RING_LEN;
      s = (m_smooth > Q16_ONE) ? 80'(Q16_ONE) : 80'(m_smooth);
      t = m_thresh[47:0];
      mix = (t * (80'd65536 - s) + (avg << 16) * s + 80'd32768) >> 16;
      m_thresh = mix[63:0];
      m_alert = ({32'd0, m_tally} << 16) > m_thresh;
      if (m_alert && m_last_ok && !listed(m_last_ip)) begin
        for (int i = 0; i < DEPTH; i++)
          if (!m_live[i] && !r.newly_blocked) begin
            m_live[i] = 1'b1;
            m_addr[i] = m_last_ip;
            m_expiry[i] = item.now_ms + m_block_ms;
            r.newly_blocked = 1'b1;
          end
      end
      r.interval_count = m_tally;
      m_tally = '0;
    end
    cnt = 0;
    for (int i = 0; i < DEPTH; i++) if (m_live[i]) cnt++;
    r.alert_active = m_alert;
    r.threshold_whole = m_thresh[47:16];
    r.entries_in_use = cnt[4:0];
    return r;
  endfunction

  // --- result checker and run limit ---
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("[request_flood_detector_blocklist] ERROR");
      $finish;
    end
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", result);
      end else begin
        automatic rfd_out_t want = pending_results.pop_front();
        if (want.request_rejected !== result.request_rejected ||
            want.alert_active !== result.alert_active ||
            want.newly_blocked !== result.newly_blocked ||
            want.threshold_whole !== result.threshold_whole ||
            want.interval_count !== result.interval_count ||
            want.entries_in_use !== result.entries_in_use) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h actual %h", want, result);
        end
      end
    end
  end

  // one command beat; prediction is taken at the accepting edge
  task automatic send_item(logic kind, logic [31:0] ip, logic [31:0] now);
    @(negedge clk);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) @(negedge clk);
    while (busy) @(negedge clk);
    start = 1'b1;
    cmd.req_type = kind;
    cmd.client_ip = ip;
    cmd.now_ms = now;
    @(posedge clk);
    pending_results.push_back(detector_step(cmd));
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASE_THRESHOLD: begin
        m_thresh = {32'd0, val} << 16;
      end
      CFG_SMOOTHING:  m_smooth = val[16:0];
      CFG_BLOCK_TIME: m_block_ms = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic request(logic [31:0] ip, int step_ms);
    now_clock += 32'(step_ms);
    send_item(REQ_CLIENT, ip, now_clock);
  endtask

  task automatic tick(int step_ms);
    now_clock += 32'(step_ms);
    send_item(REQ_TICK, $urandom, now_clock);
  endtask

  task automatic test_defaults();
    tick(0);                      // tick with no remembered client
    request(32'h0000_0000, 10);
    request(32'hFFFF_FFFF, 10);
    tick(1000);
  endtask

  task automatic test_block_and_expiry();
    write_reg(CFG_BASE_THRESHOLD, 32'd0);
    write_reg(CFG_SMOOTHING, 32'd0);
    write_reg(CFG_BLOCK_TIME, 32'd500);
    request(32'hC0A8_0001, 5);
    request(32'hC0A8_0001, 5);
    tick(5);                      // alert, client gets listed
    request(32'hC0A8_0001, 5);    // rejected
    tick(5);                      // already listed, alert off
    request(32'hC0A8_0001, 600);  // expired, counted again
    write_reg(CFG_BLOCK_TIME, 32'h8000_0000);
    tick(1);                      // listed with expiry half a wrap ahead
    request(32'h0A00_0002, 1);    // that entry is still live
    write_reg(CFG_BLOCK_TIME, 32'hFFFF_FFFF);
    write_reg(CFG_SMOOTHING, 32'(Q16_ONE));
    tick(1);
    write_reg(CFG_SMOOTHING, 32'h0001_FFFF); // oversized weight
    request(32'h0A00_0003, 1);
    tick(1);
    write_reg(CFG_UNUSED, 32'h1234_5678);    // unused index
    write_reg(CFG_BASE_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(CFG_SMOOTHING, 32'd0);
    request(32'h0A00_0004, 1);
    tick(1);
  endtask

  task automatic test_table_full();
    write_reg(CFG_BASE_THRESHOLD, 32'd0);
    write_reg(CFG_BLOCK_TIME, 32'h7000_0000);
    for (int i = 0; i < DEPTH + 2; i++) begin
      request(32'h5000_0000 + i, 1);
      tick(1);
    end
    now_clock = 32'hFFFF_FF00;    // time wraps under live entries
    request(32'h5000_0001, 1);
    tick(300);
  endtask

  task automatic reset_pool();
    for (int i = 0; i < 24; i++) ip_pool[i] = $urandom;
  endtask

  task automatic test_random(int items, int pct);
    int kind;
    gap_pct = pct;
    reset_pool();
    write_reg(CFG_BASE_THRESHOLD, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8));
    kind = $urandom_range(0, 9);
    write_reg(CFG_SMOOTHING, kind == 0 ? 32'(Q16_ONE) : kind == 1 ? {15'd0, 17'($urandom)}
                              : $urandom_range(0, 40000));
    kind = $urandom_range(0, 5);
    write_reg(CFG_BLOCK_TIME, kind == 0 ? $urandom : kind == 1 ? 32'hFFFF_FFFF
                              : $urandom_range(50, 4000));
    now_clock = $urandom;
    for (int n = 0; n < items; n++) begin
      if (n == items / 2) wait_idle();    // sender holds until drained
      if ($urandom_range(0, 3) == 0)
        tick($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 400));
      else
        request($urandom_range(0, 9) == 0 ? $urandom : ip_pool[$urandom_range(0, 23)],
                $urandom_range(0, 9) == 0 ? $urandom_range(0, 100000)
                                          : $urandom_range(0, 200));
    end
  endtask

  initial begin
    model_reset();
    now_clock = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_defaults();
    test_block_and_expiry();
    test_table_full();
    test_random(300, 0);
    test_random(300, 47);
    test_random(300, 34);
    test_random(300, 0);
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[request_flood_detector_blocklist] OK");
    else
      $display("[request_flood_detector_blocklist] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

>>> request_flood_detector_blocklist.f
hdl/rfd_pkg.sv
hdl/rfd_ram.sv
hdl/request_flood_detector_blocklist.sv
verif/testbench.sv
